[rtl/ctb_pkg.sv]
// ----------------------------------------------------------------------------
// ctb_pkg
// Shared types and constants for the countdown timer bank.
// ----------------------------------------------------------------------------
package ctb_pkg;

  localparam logic [2:0]  CMD_TICK   = 3'd0;
  localparam logic [2:0]  CMD_LOAD   = 3'd1;
  localparam logic [2:0]  CMD_ACTION = 3'd2;
  localparam logic [2:0]  CMD_START  = 3'd3;
  localparam logic [2:0]  CMD_STOP   = 3'd4;
  localparam logic [2:0]  CMD_CLEAR  = 3'd5;

  localparam logic [15:0] RELOAD_RESET = 16'd1000;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  timer_index;
    logic [15:0] count_value;
    logic        action_present;
  } in_word_t;

  typedef struct packed {
    logic [5:0] expired_index;
    logic       last_of_run;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_FLUSH
  } state_t;

  // scan controls from the sequencer
  typedef struct packed {
    logic rd_en;
    logic tick_wr;
  } scan_ctl_t;

  // all store controls
  typedef struct packed {
    logic rd_en;
    logic tick_wr;
    logic load;
    logic set_action;
    logic start;
    logic stop;
    logic clear;
  } store_ctl_t;

  // status of the timer under the scan pointer
  typedef struct packed {
    logic active;
    logic fire;
  } tmr_stat_t;

endpackage

[rtl/ctb_store.sv]
// ----------------------------------------------------------------------------
// ctb_store
// Timer count memory, enable and action flags, and the shared
// decrement / zero-compare unit used by the tick scan.
// ----------------------------------------------------------------------------
module ctb_store #(
  parameter int TIMERS = 8,
  parameter int IW     = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctb_pkg::store_ctl_t   ctl,
  input  logic [IW-1:0]         cmd_addr,
  input  logic [IW-1:0]         scan_addr,
  input  logic [15:0]           load_value,
  input  logic                  action_value,
  input  logic [15:0]           reload_count,
  output ctb_pkg::tmr_stat_t    stat
);
  import ctb_pkg::*;

  logic [15:0]       count_mem [TIMERS];
  logic [15:0]       rd_data;
  logic [TIMERS-1:0] count_ok;
  logic [TIMERS-1:0] enabled;
  logic [TIMERS-1:0] attached;

  logic [15:0] cur_count;
  logic [15:0] dec_count;
  logic [15:0] new_count;

  // shared decrement and compare
  always_comb begin
    cur_count   = count_ok[scan_addr] ? rd_data : 16'd0;
    dec_count   = cur_count - 16'd1;
    stat.active = enabled[scan_addr] && (cur_count != 16'd0);
    stat.fire   = stat.active && (dec_count == 16'd0) && attached[scan_addr];
    new_count   = stat.fire ? reload_count : dec_count;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      count_mem[cmd_addr] <= load_value;
    end else if (ctl.tick_wr) begin
      count_mem[scan_addr] <= new_count;
    end
    if (ctl.rd_en) begin
      rd_data <= count_mem[scan_addr];
    end
  end

  // an entry never written since clear reads as zero
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      count_ok <= '0;
      enabled  <= '0;
      attached <= '0;
    end else begin
      if (ctl.load) begin
        count_ok[cmd_addr] <= 1'b1;
      end
      if (ctl.tick_wr) begin
        count_ok[scan_addr] <= 1'b1;
      end
      if (ctl.set_action) begin
        attached[cmd_addr] <= action_value;
      end
      if (ctl.start) begin
        enabled[cmd_addr] <= 1'b1;
      end
      if (ctl.stop) begin
        enabled[cmd_addr] <= 1'b0;
      end
    end
  end

  a_fire_active: assert property (@(posedge clk) disable iff (rst)
    stat.fire |-> stat.active)
    else $error("fire without active timer");

  a_load_not_in_scan: assert property (@(posedge clk) disable iff (rst)
    ctl.tick_wr |-> !ctl.load && !ctl.clear)
    else $error("command write during tick scan");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    ctl.clear |=> count_ok == '0 && enabled == '0 && attached == '0)
    else $error("clear left state behind");

endmodule

[rtl/ctb_seq.sv]
// ----------------------------------------------------------------------------
// ctb_seq
// Tick sequencer: walks the timers one by one, holds the latest expiry
// until the next one or the end of the scan decides its last flag.
// ----------------------------------------------------------------------------
module ctb_seq #(
  parameter int TIMERS = 8,
  parameter int IW     = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [2:0]           command,
  output logic                 in_stall,
  input  ctb_pkg::tmr_stat_t   stat,
  output ctb_pkg::scan_ctl_t   scan_ctl,
  output logic [IW-1:0]        scan_addr,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ctb_pkg::out_word_t   out_word
);
  import ctb_pkg::*;

  localparam logic [IW-1:0] LAST_ADDR = IW'(TIMERS - 1);

  state_t        state;
  state_t        state_next;
  logic          pend_valid;
  logic [IW-1:0] pend_idx;

  logic tick_start;
  logic out_free;
  logic stall_upd;
  logic push_mid;
  logic push_last;

  assign in_stall   = (state != ST_IDLE);
  assign tick_start = in_valid && !in_stall && (command == CMD_TICK);
  assign out_free   = !out_valid || !out_stall;
  // a second expiry needs the held one moved to the output first
  assign stall_upd  = stat.fire && pend_valid && !out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (tick_start) state_next = ST_READ;
      ST_READ:   state_next = ST_UPDATE;
      ST_UPDATE: begin
        if (stall_upd) begin
          state_next = ST_UPDATE;
        end else if (scan_addr == LAST_ADDR) begin
          state_next = ST_FLUSH;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_FLUSH:  if (!pend_valid || out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    scan_ctl.rd_en   = 1'b0;
    scan_ctl.tick_wr = 1'b0;
    push_mid         = 1'b0;
    push_last        = 1'b0;
    unique case (state)
      ST_IDLE:   ;
      ST_READ:   scan_ctl.rd_en = 1'b1;
      ST_UPDATE: begin
        scan_ctl.tick_wr = stat.active && !stall_upd;
        push_mid         = stat.fire && pend_valid && out_free;
      end
      ST_FLUSH:  push_last = pend_valid && out_free;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
    end else if (tick_start) begin
      scan_addr <= '0;
    end else if (state == ST_UPDATE && !stall_upd && scan_addr != LAST_ADDR) begin
      scan_addr <= IW'(scan_addr + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (state == ST_UPDATE && stat.fire && !stall_upd) begin
      pend_valid <= 1'b1;
    end else if (push_last) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_UPDATE && stat.fire && !stall_upd) begin
      pend_idx <= scan_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_mid || push_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_mid || push_last) begin
      out_word.expired_index <= 6'(pend_idx);
      out_word.last_of_run   <= push_last;
    end
  end

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !pend_valid)
    else $error("held expiry left after scan");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE && stall_upd) |=> state == ST_UPDATE && $stable(scan_addr))
    else $error("scan moved on while blocked");

  a_push_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_UPDATE || $past(state) == ST_FLUSH)
    else $error("result word outside a scan");

  a_flush_done: assert property (@(posedge clk) disable iff (rst)
    push_last |=> state == ST_IDLE)
    else $error("scan did not finish after last word");

endmodule

[rtl/countdown_timer_bank_unit.sv]
// ----------------------------------------------------------------------------
// countdown_timer_bank_unit
// Bank of countdown timers with load, action, start, stop, clear and tick
// commands. Ticks walk the timers and report each expiring timer.
// ----------------------------------------------------------------------------
// latency: load, action, start, stop and clear take effect in the accept cycle
// throughput: a non-tick command every cycle while no tick scan is running; a tick
//   occupies the unit for one memory read and one update per timer, then a flush,
//   and longer while the output side holds back an expiry word mid-scan or in the flush
// reset: all timers zero, stopped, no action; reload count 1000; no clear pass
module countdown_timer_bank_unit #(
  parameter int TIMERS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ctb_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output ctb_pkg::out_word_t  out_word,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data
);
  import ctb_pkg::*;

  localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;

  logic [15:0]   reload_count;
  logic          in_accept;
  logic          idx_ok;
  logic [IW-1:0] scan_addr;
  scan_ctl_t     scan_ctl;
  store_ctl_t    store_ctl;
  tmr_stat_t     stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      reload_count <= RELOAD_RESET;
    end else if (cfg_we) begin
      reload_count <= cfg_data;
    end
  end

  assign in_accept = in_valid && !in_stall;
  assign idx_ok    = {1'b0, in_word.timer_index} < 9'(TIMERS);

  always_comb begin
    store_ctl.rd_en      = scan_ctl.rd_en;
    store_ctl.tick_wr    = scan_ctl.tick_wr;
    store_ctl.load       = in_accept && idx_ok && (in_word.command == CMD_LOAD);
    store_ctl.set_action = in_accept && idx_ok && (in_word.command == CMD_ACTION);
    store_ctl.start      = in_accept && idx_ok && (in_word.command == CMD_START);
    store_ctl.stop       = in_accept && idx_ok && (in_word.command == CMD_STOP);
    store_ctl.clear      = in_accept && (in_word.command == CMD_CLEAR);
  end

  ctb_store #(
    .TIMERS (TIMERS),
    .IW     (IW)
  ) u_store (
    .clk          (clk),
    .rst          (rst),
    .ctl          (store_ctl),
    .cmd_addr     (in_word.timer_index[IW-1:0]),
    .scan_addr    (scan_addr),
    .load_value   (in_word.count_value),
    .action_value (in_word.action_present),
    .reload_count (reload_count),
    .stat         (stat)
  );

  ctb_seq #(
    .TIMERS (TIMERS),
    .IW     (IW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .command   (in_word.command),
    .in_stall  (in_stall),
    .stat      (stat),
    .scan_ctl  (scan_ctl),
    .scan_addr (scan_addr),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

[bench/tb_countdown_timer_bank_unit.sv]
// ----------------------------------------------------------------------------
// tb_countdown_timer_bank_unit
// Self-checking bench for the countdown timer bank. A shadow copy of the
// timer store predicts the expiry words of every accepted command. Each
// expiry word that leaves the unit is compared against the oldest
// prediction. Directed cases come first, then a full-bank backpressure run
// and random command traffic. Both handshakes see random idling throughout.
// ----------------------------------------------------------------------------
module tb_countdown_timer_bank_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ctb_pkg::*;

  localparam int TIMERS       = 8;
  localparam int SCAN_CYCLES  = 2 * TIMERS + 6;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 56;
  localparam int IN_BITS      = $bits(in_word_t);

  // command codes the unit must ignore
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_word_t    in_word   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_data  = '0;

  // shadow timer store
  logic [15:0] shadow_count [TIMERS];
  bit          shadow_enabled [TIMERS];
  bit          shadow_action [TIMERS];
  logic [15:0] shadow_reload;

  out_word_t   pending_expiry [$];
  int          expiries_predicted = 0;
  int          mismatches = 0;
  int          cycle_count = 0;
  int          burst_left = 0;

  // receiver stall control
  int          hold_reqs = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          stall_mode = 0;
  int          mode_left = 0;

  countdown_timer_bank_unit #(
    .TIMERS(TIMERS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: long hold-off on request, otherwise a stall pattern that
  // switches between quiet, light and heavy stretches
  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(10, 60);
      end
      mode_left--;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 4) < 3);
      endcase
    end
  end

  // compare each expiry word against the oldest prediction
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_expiry.size() == 0) begin
        $error("unexpected expiry word: expired_index=%0d last_of_run=%0b",
               out_word.expired_index, out_word.last_of_run);
        mismatches++;
      end else begin
        want = pending_expiry.pop_front();
        if (out_word.expired_index !== want.expired_index) begin
          $error("expired_index: expected %0d, actual %0d",
                 want.expired_index, out_word.expired_index);
          mismatches++;
        end
        if (out_word.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0b, actual %0b",
                 want.last_of_run, out_word.last_of_run);
          mismatches++;
        end
      end
    end
  end

  task automatic clear_shadow();
    for (int i = 0; i < TIMERS; i++) begin
      shadow_count[i]   = '0;
      shadow_enabled[i] = 1'b0;
      shadow_action[i]  = 1'b0;
    end
  endtask

  // update the shadow store and queue the expiry words a command causes
  task automatic apply_command(input in_word_t w);
    int        fired [$];
    out_word_t hit;
    case (w.command)
      CMD_TICK: begin
        for (int i = 0; i < TIMERS; i++) begin
          if (shadow_enabled[i] && shadow_count[i] != 16'd0) begin
            shadow_count[i] = shadow_count[i] - 16'd1;
            if (shadow_count[i] == 16'd0 && shadow_action[i]) begin
              fired.push_back(i);
              shadow_count[i] = shadow_reload;
            end
          end
        end
        foreach (fired[k]) begin
          hit.expired_index = 6'(fired[k]);
          hit.last_of_run   = (k == fired.size() - 1);
          pending_expiry.push_back(hit);
          expiries_predicted++;
        end
      end
      CMD_CLEAR: clear_shadow();
      CMD_LOAD, CMD_ACTION, CMD_START, CMD_STOP: begin
        if (w.timer_index < TIMERS) begin
          case (w.command)
            CMD_LOAD:   shadow_count[w.timer_index]   = w.count_value;
            CMD_ACTION: shadow_action[w.timer_index]  = w.action_present;
            CMD_START:  shadow_enabled[w.timer_index] = 1'b1;
            default:    shadow_enabled[w.timer_index] = 1'b0;
          endcase
        end
      end
      default: ;
    endcase
  endtask

  function automatic in_word_t make_cmd(input logic [2:0] cmd, input logic [7:0] idx,
                                        input logic [15:0] cnt, input logic act);
    in_word_t w;
    w.command        = cmd;
    w.timer_index    = idx;
    w.count_value    = cnt;
    w.action_present = act;
    return w;
  endfunction

  // offer one word, hold it until accepted, then maybe open a gap
  task automatic send_command(input in_word_t w);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    apply_command(w);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30)
                                               : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_expiry.size() != 0) @(posedge clk);
    // a tick may still be scanning timers that fire nothing
    repeat (SCAN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reload(input logic [15:0] value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    shadow_reload = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic arm_timer(input int idx, input logic [15:0] cnt);
    send_command(make_cmd(CMD_LOAD, 8'(idx), cnt, 1'b0));
    send_command(make_cmd(CMD_ACTION, 8'(idx), 16'h0000, 1'b1));
    send_command(make_cmd(CMD_START, 8'(idx), 16'h0000, 1'b0));
  endtask

  function automatic in_word_t random_command();
    in_word_t w;
    int       pick;
    w    = IN_BITS'($urandom);
    pick = $urandom_range(0, 99);
    // mostly meaningful commands with random content, some raw noise
    if (pick < 94) begin
      if (pick < 32)      w.command = CMD_TICK;
      else if (pick < 52) w.command = CMD_LOAD;
      else if (pick < 64) w.command = CMD_ACTION;
      else if (pick < 78) w.command = CMD_START;
      else if (pick < 85) w.command = CMD_STOP;
      else if (pick < 88) w.command = CMD_CLEAR;
      else                w.command = $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
      if ($urandom_range(0, 9) != 0) w.timer_index = 8'($urandom_range(0, TIMERS - 1));
      if ($urandom_range(0, 7) != 0) w.count_value = 16'($urandom_range(1, 5));
      w.action_present = ($urandom_range(0, 3) != 0);
    end
    return w;
  endfunction

  task automatic test_default_reload();
    arm_timer(0, 16'd1);
    send_command(make_cmd(CMD_TICK, 8'd0, 16'd0, 1'b0));
    send_command(make_cmd(CMD_TICK, 8'd0, 16'd0, 1'b0));
    wait_for_drain();
  endtask

  task automatic test_field_extremes();
    write_reload(16'hFFFF);
    arm_timer(7, 16'hFFFF);
    arm_timer(3, 16'd1);
    send_command(make_cmd(CMD_TICK, 8'd0, 16'd0, 1'b0));
    // tick ignores every field but the command
    send_command(make_cmd(CMD_TICK, 8'hFF, 16'hFFFF, 1'b1));
    wait_for_drain();
  endtask

  task automatic test_ignored_commands();
    send_command(make_cmd(CMD_LOAD, 8'd8, 16'd1, 1'b0));
    send_command(make_cmd(CMD_LOAD, 8'hFF, 16'hFFFF, 1'b1));
    send_command(make_cmd(CMD_ACTION, 8'hFF, 16'd0, 1'b0));
    send_command(make_cmd(CMD_STOP, 8'd200, 16'd0, 1'b0));
    send_command(make_cmd(CMD_SPARE_A, 8'd0, 16'd1, 1'b1));
    send_command(make_cmd(CMD_SPARE_B, 8'hFF, 16'hFFFF, 1'b1));
    send_command(make_cmd(CMD_TICK, 8'd0, 16'd0, 1'b0));
    wait_for_drain();
  endtask

  task automatic test_silent_expiry();
    // a timer with no action counts down to zero and stays there
    send_command(make_cmd(CMD_LOAD, 8'd2, 16'd1, 1'b0));
    send_command(make_cmd(CMD_START, 8'd2, 16'd0, 1'b0));
    send_command(make_cmd(CMD_TICK, 8'd0, 16'd0, 1'b0));
    send_command(make_cmd(CMD_STOP, 8'd7, 16'd0, 1'b0));
    send_command(make_cmd(CMD_TICK, 8'd0, 16'd0, 1'b0));
    wait_for_drain();
  endtask

  task automatic test_zero_reload();
    write_reload(16'd0);
    send_command(make_cmd(CMD_LOAD, 8'd0, 16'd1, 1'b0));
    send_command(make_cmd(CMD_TICK, 8'd0, 16'd0, 1'b0));
    send_command(make_cmd(CMD_TICK, 8'd0, 16'd0, 1'b0));
    send_command(make_cmd(CMD_ACTION, 8'd0, 16'd0, 1'b0));
    wait_for_drain();
  endtask

  task automatic test_clear_all();
    send_command(make_cmd(CMD_CLEAR, 8'hFF, 16'hFFFF, 1'b1));
    send_command(make_cmd(CMD_TICK, 8'd0, 16'd0, 1'b0));
    wait_for_drain();
  endtask

  task automatic test_full_bank_backpressure();
    write_reload(16'd1);
    for (int i = 0; i < TIMERS; i++) arm_timer(i, 16'd1);
    // every tick fires all timers, and the receiver first holds off for a long stretch
    hold_reqs++;
    repeat (12) send_command(make_cmd(CMD_TICK, 8'd0, 16'd0, 1'b0));
    wait_for_drain();
  endtask

  task automatic test_random_traffic();
    in_word_t w;
    write_reload(16'($urandom_range(1, 3)));
    for (int sent = 1; sent <= RANDOM_ITEMS; sent++) begin
      w = random_command();
      send_command(w);
      if (sent % 28 == 0) begin
        wait_for_drain();
        write_reload(16'($urandom_range(1, 6)));
      end
    end
    wait_for_drain();
  endtask

  initial begin
    clear_shadow();
    shadow_reload = RELOAD_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_reload();
    test_field_extremes();
    test_ignored_commands();
    test_silent_expiry();
    test_zero_reload();
    test_clear_all();
    test_full_bank_backpressure();
    test_random_traffic();

    wait_for_drain();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
rtl/ctb_pkg.sv
rtl/ctb_store.sv
rtl/ctb_seq.sv
rtl/countdown_timer_bank_unit.sv
bench/tb_countdown_timer_bank_unit.sv
